// ===== rtl/rhpb_pkg.sv =====
// shared types, constants and helper functions of the colour sensor post-processing block
`timescale 1ns / 1ps

package rhpb_pkg;

  // field widths
  localparam int unsigned CountW  = 16;
  localparam int unsigned PctW    = 7;
  localparam int unsigned HueW    = 9;
  localparam int unsigned HueBcdW = 10;
  localparam int unsigned CntBcdW = 19;

  // internal widths
  localparam int unsigned TotalW = 18;  // sum of three counts
  localparam int unsigned NormW  = 13;  // 1.12 scaled count, up to 4096
  localparam int unsigned PnumW  = 23;  // count * 100 + total / 2
  localparam int unsigned HnumW  = 21;  // magnitude of the hue ratio numerator
  localparam int unsigned QuoW   = 9;   // quotient bits of every divider
  localparam int unsigned DabW   = 36;  // double dabble shift register
  localparam int unsigned PdivW  = PnumW + 3;

  // pipeline shape
  localparam int unsigned DivSteps = QuoW;
  localparam int unsigned Latency  = DivSteps + 5;

  // channel holding the maximum
  localparam logic [1:0] MaxRed   = 2'd0;
  localparam logic [1:0] MaxGreen = 2'd1;
  localparam logic [1:0] MaxBlue  = 2'd2;

  // hue constants
  localparam logic signed [11:0] BaseGreen = 12'sd512;
  localparam logic signed [11:0] BaseBlue  = 12'sd1024;
  localparam logic signed [18:0] DegScale  = 19'sd60;
  localparam logic signed [18:0] FullTurn  = 19'sd92160;

  // one divider stage: percent and hue dividers side by side, plus carried payload
  typedef struct packed {
    logic [PnumW-1:0]   rem_r;
    logic [PnumW-1:0]   rem_g;
    logic [PnumW-1:0]   rem_b;
    logic [TotalW-1:0]  total;
    logic [QuoW-1:0]    quo_r;
    logic [QuoW-1:0]    quo_g;
    logic [QuoW-1:0]    quo_b;
    logic               zero_total;
    logic [HnumW-1:0]   rem_h;
    logic [NormW-1:0]   delta;
    logic [QuoW-1:0]    quo_h;
    logic               neg;
    logic               flat;
    logic [1:0]         which;
    logic [CntBcdW-1:0] bcd_r;
    logic [CntBcdW-1:0] bcd_g;
    logic [CntBcdW-1:0] bcd_b;
  } div_t;

  // count * 4096 / 65535, truncated
  function automatic logic [NormW-1:0] norm12(input logic [CountW-1:0] cnt);
    logic [28:0] x;
    logic [28:0] s;
    x = {1'b0, cnt, 12'b0};
    s = x + (x >> 16) + 29'd1;
    return s[28:16];
  endfunction

  // eight double dabble iterations over five digits
  function automatic logic [DabW-1:0] dabble8(input logic [DabW-1:0] s_in);
    logic [DabW-1:0] s;
    s = s_in;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 5; j++) begin
        if (s[CountW+4*j +: 4] >= 4'd5) s[CountW+4*j +: 4] = s[CountW+4*j +: 4] + 4'd3;
      end
      s = s << 1;
    end
    return s;
  endfunction

endpackage

// ===== rtl/rgb_hue_percent_bcd.sv =====
// colour sensor post-processing: channel percentages, hue angle and bcd forms
//
// Usage: drive red_count_i, green_count_i and blue_count_i and raise start for one
// cycle; the request is taken at the edge where start is high and busy is low.
// busy stays low, so a new request may be taken at every clock edge.
// Each request gives exactly one result: done_o is high for one cycle and the
// result ports hold the percentages, hue and bcd values until the next result.
// The result appears once the request has passed through every stage of the
// datapath. Throughput: one request per cycle, set by the fully pipelined
// datapath (input scaling, two set-up stages, nine restoring divider stages
// shared by the percent and hue dividers, hue assembly, hue bcd output stage).
// The receiver cannot hold results off; every result is shown once.
// Reset clears all stage valid bits at once; requests in flight are dropped and
// no result appears until a new request is taken.
`timescale 1ns / 1ps

module rgb_hue_percent_bcd (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [rhpb_pkg::CountW-1:0]     red_count_i,
  input  logic [rhpb_pkg::CountW-1:0]     green_count_i,
  input  logic [rhpb_pkg::CountW-1:0]     blue_count_i,
  output logic                            done_o,
  output logic [rhpb_pkg::PctW-1:0]       red_percent_o,
  output logic [rhpb_pkg::PctW-1:0]       green_percent_o,
  output logic [rhpb_pkg::PctW-1:0]       blue_percent_o,
  output logic [rhpb_pkg::HueW-1:0]       hue_degrees_o,
  output logic [rhpb_pkg::HueBcdW-1:0]    hue_bcd_o,
  output logic [rhpb_pkg::CntBcdW-1:0]    red_bcd_o,
  output logic [rhpb_pkg::CntBcdW-1:0]    green_bcd_o,
  output logic [rhpb_pkg::CntBcdW-1:0]    blue_bcd_o
);

  logic accept;

  // stage 1 registers
  logic                          v1_q;
  logic [rhpb_pkg::CountW-1:0]   r1_q, g1_q, b1_q;
  logic [rhpb_pkg::TotalW-1:0]   tot1_q;
  logic [rhpb_pkg::NormW-1:0]    nr1_q, ng1_q, nb1_q;

  // stage 2 signals and registers
  logic [rhpb_pkg::PnumW-1:0]    pr2_d, pg2_d, pb2_d;
  logic [rhpb_pkg::NormW-1:0]    cmin, cmax, dlt2_d;
  logic [1:0]                    wh2_d;
  logic signed [13:0]            d2_d;
  logic                          v2_q;
  logic [rhpb_pkg::PnumW-1:0]    pr2_q, pg2_q, pb2_q;
  logic [rhpb_pkg::TotalW-1:0]   tot2_q;
  logic [rhpb_pkg::NormW-1:0]    dlt2_q;
  logic signed [13:0]            d2_q;
  logic [1:0]                    wh2_q;
  logic [rhpb_pkg::DabW-1:0]     dr2_q, dg2_q, db2_q;

  // divider stages
  logic signed [21:0]            hnum;
  logic [rhpb_pkg::DabW-1:0]     dr3, dg3, db3;
  rhpb_pkg::div_t                dv0_d;
  rhpb_pkg::div_t                dv_q [rhpb_pkg::DivSteps+1];
  rhpb_pkg::div_t                dv_d [rhpb_pkg::DivSteps];
  logic                          vv_q [rhpb_pkg::DivSteps+1];

  // hue stage
  rhpb_pkg::div_t                dl;
  logic signed [10:0]            qs;
  logic signed [11:0]            hsum;
  logic signed [18:0]            hdeg;
  logic [rhpb_pkg::HueW-1:0]     hue_d;
  logic                          vh_q;
  logic [rhpb_pkg::PctW-1:0]     prh_q, pgh_q, pbh_q;
  logic [rhpb_pkg::HueW-1:0]     hueh_q;
  logic [rhpb_pkg::CntBcdW-1:0]  brh_q, bgh_q, bbh_q;

  // output stage
  logic [1:0]                    hund;
  logic [6:0]                    hrem;
  logic [14:0]                   tprod;
  logic [3:0]                    tens;
  logic [6:0]                    ones;
  logic                          done_q;
  logic [rhpb_pkg::PctW-1:0]     pro_q, pgo_q, pbo_q;
  logic [rhpb_pkg::HueW-1:0]     hueo_q;
  logic [rhpb_pkg::HueBcdW-1:0]  hbo_q;
  logic [rhpb_pkg::CntBcdW-1:0]  bro_q, bgo_q, bbo_q;

  // request handshake: the pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      vh_q   <= 1'b0;
      done_q <= 1'b0;
      for (int k = 0; k <= rhpb_pkg::DivSteps; k++) vv_q[k] <= 1'b0;
    end else begin
      v1_q     <= accept;
      v2_q     <= v1_q;
      vv_q[0]  <= v2_q;
      for (int k = 0; k < rhpb_pkg::DivSteps; k++) vv_q[k+1] <= vv_q[k];
      vh_q     <= vv_q[rhpb_pkg::DivSteps];
      done_q   <= vh_q;
    end
  end

  // stage 1: total and 1.12 scaling
  always_ff @(posedge clk_i) begin
    if (accept) begin
      r1_q   <= red_count_i;
      g1_q   <= green_count_i;
      b1_q   <= blue_count_i;
      tot1_q <= rhpb_pkg::TotalW'(red_count_i) + rhpb_pkg::TotalW'(green_count_i)
                + rhpb_pkg::TotalW'(blue_count_i);
      nr1_q  <= rhpb_pkg::norm12(red_count_i);
      ng1_q  <= rhpb_pkg::norm12(green_count_i);
      nb1_q  <= rhpb_pkg::norm12(blue_count_i);
    end
  end

  // stage 2: percent numerators
  assign pr2_d = ({7'b0, r1_q} * 23'd100) + {6'b0, tot1_q[17:1]};
  assign pg2_d = ({7'b0, g1_q} * 23'd100) + {6'b0, tot1_q[17:1]};
  assign pb2_d = ({7'b0, b1_q} * 23'd100) + {6'b0, tot1_q[17:1]};

  // stage 2: maximum, minimum and hue difference, red then green win ties
  always_comb begin
    cmin  = nr1_q;
    cmax  = nr1_q;
    wh2_d = rhpb_pkg::MaxRed;
    if (ng1_q < cmin) begin
      cmin = ng1_q;
    end else if (ng1_q > cmax) begin
      cmax  = ng1_q;
      wh2_d = rhpb_pkg::MaxGreen;
    end
    if (nb1_q < cmin) begin
      cmin = nb1_q;
    end else if (nb1_q > cmax) begin
      cmax  = nb1_q;
      wh2_d = rhpb_pkg::MaxBlue;
    end
    dlt2_d = cmax - cmin;
    unique case (wh2_d)
      rhpb_pkg::MaxRed:   d2_d = $signed({1'b0, ng1_q}) - $signed({1'b0, nb1_q});
      rhpb_pkg::MaxGreen: d2_d = $signed({1'b0, nb1_q}) - $signed({1'b0, nr1_q});
      rhpb_pkg::MaxBlue:  d2_d = $signed({1'b0, nr1_q}) - $signed({1'b0, ng1_q});
      default:            d2_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      pr2_q  <= pr2_d;
      pg2_q  <= pg2_d;
      pb2_q  <= pb2_d;
      tot2_q <= tot1_q;
      dlt2_q <= dlt2_d;
      d2_q   <= d2_d;
      wh2_q  <= wh2_d;
      dr2_q  <= rhpb_pkg::dabble8({20'b0, r1_q});
      dg2_q  <= rhpb_pkg::dabble8({20'b0, g1_q});
      db2_q  <= rhpb_pkg::dabble8({20'b0, b1_q});
    end
  end

  // stage 3: signed hue numerator, finish bcd conversion
  assign hnum = $signed({d2_q, 8'b0}) + $signed({10'b0, dlt2_q[12:1]});
  assign dr3  = rhpb_pkg::dabble8(dr2_q);
  assign dg3  = rhpb_pkg::dabble8(dg2_q);
  assign db3  = rhpb_pkg::dabble8(db2_q);

  always_comb begin
    dv0_d            = '0;
    dv0_d.rem_r      = pr2_q;
    dv0_d.rem_g      = pg2_q;
    dv0_d.rem_b      = pb2_q;
    dv0_d.total      = tot2_q;
    dv0_d.zero_total = (tot2_q == '0);
    dv0_d.neg        = hnum[21];
    dv0_d.rem_h      = hnum[21] ? rhpb_pkg::HnumW'(-hnum) : hnum[20:0];
    dv0_d.delta      = dlt2_q;
    dv0_d.flat       = (dlt2_q == '0);
    dv0_d.which      = wh2_q;
    dv0_d.bcd_r      = dr3[34:16];
    dv0_d.bcd_g      = dg3[34:16];
    dv0_d.bcd_b      = db3[34:16];
  end

  // restoring divider steps, most significant quotient bit first
  always_comb begin
    logic [rhpb_pkg::PdivW-1:0] dp;
    logic [rhpb_pkg::HnumW-1:0] dh;
    for (int k = 0; k < rhpb_pkg::DivSteps; k++) begin
      dv_d[k] = dv_q[k];
      dp = rhpb_pkg::PdivW'(dv_q[k].total) << (rhpb_pkg::DivSteps - 1 - k);
      dh = rhpb_pkg::HnumW'(dv_q[k].delta) << (rhpb_pkg::DivSteps - 1 - k);
      if (rhpb_pkg::PdivW'(dv_q[k].rem_r) >= dp) begin
        dv_d[k].rem_r = dv_q[k].rem_r - dp[rhpb_pkg::PnumW-1:0];
        dv_d[k].quo_r = {dv_q[k].quo_r[rhpb_pkg::QuoW-2:0], 1'b1};
      end else begin
        dv_d[k].quo_r = {dv_q[k].quo_r[rhpb_pkg::QuoW-2:0], 1'b0};
      end
      if (rhpb_pkg::PdivW'(dv_q[k].rem_g) >= dp) begin
        dv_d[k].rem_g = dv_q[k].rem_g - dp[rhpb_pkg::PnumW-1:0];
        dv_d[k].quo_g = {dv_q[k].quo_g[rhpb_pkg::QuoW-2:0], 1'b1};
      end else begin
        dv_d[k].quo_g = {dv_q[k].quo_g[rhpb_pkg::QuoW-2:0], 1'b0};
      end
      if (rhpb_pkg::PdivW'(dv_q[k].rem_b) >= dp) begin
        dv_d[k].rem_b = dv_q[k].rem_b - dp[rhpb_pkg::PnumW-1:0];
        dv_d[k].quo_b = {dv_q[k].quo_b[rhpb_pkg::QuoW-2:0], 1'b1};
      end else begin
        dv_d[k].quo_b = {dv_q[k].quo_b[rhpb_pkg::QuoW-2:0], 1'b0};
      end
      if (dv_q[k].rem_h >= dh) begin
        dv_d[k].rem_h = dv_q[k].rem_h - dh;
        dv_d[k].quo_h = {dv_q[k].quo_h[rhpb_pkg::QuoW-2:0], 1'b1};
      end else begin
        dv_d[k].quo_h = {dv_q[k].quo_h[rhpb_pkg::QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) dv_q[0] <= dv0_d;
    for (int k = 0; k < rhpb_pkg::DivSteps; k++) begin
      if (vv_q[k]) dv_q[k+1] <= dv_d[k];
    end
  end

  // hue assembly: 60 * (base + ratio), wrapped when negative, whole degrees
  assign dl = dv_q[rhpb_pkg::DivSteps];
  always_comb begin
    qs = dl.neg ? -$signed({2'b0, dl.quo_h}) : $signed({2'b0, dl.quo_h});
    unique case (dl.which)
      rhpb_pkg::MaxGreen: hsum = rhpb_pkg::BaseGreen + 12'(qs);
      rhpb_pkg::MaxBlue:  hsum = rhpb_pkg::BaseBlue + 12'(qs);
      default:            hsum = 12'(qs);
    endcase
    hdeg = 19'(hsum) * rhpb_pkg::DegScale;
    if (hdeg < 0) hdeg = hdeg + rhpb_pkg::FullTurn;
    hue_d = dl.flat ? '0 : hdeg[16:8];
  end

  always_ff @(posedge clk_i) begin
    if (vv_q[rhpb_pkg::DivSteps]) begin
      prh_q  <= dl.zero_total ? '0 : dl.quo_r[rhpb_pkg::PctW-1:0];
      pgh_q  <= dl.zero_total ? '0 : dl.quo_g[rhpb_pkg::PctW-1:0];
      pbh_q  <= dl.zero_total ? '0 : dl.quo_b[rhpb_pkg::PctW-1:0];
      hueh_q <= hue_d;
      brh_q  <= dl.bcd_r;
      bgh_q  <= dl.bcd_g;
      bbh_q  <= dl.bcd_b;
    end
  end

  // hue bcd: hundreds by compare, tens by reciprocal multiply
  always_comb begin
    priority if (hueh_q >= 9'd300) begin
      hund = 2'd3;
      hrem = 7'(hueh_q - 9'd300);
    end else if (hueh_q >= 9'd200) begin
      hund = 2'd2;
      hrem = 7'(hueh_q - 9'd200);
    end else if (hueh_q >= 9'd100) begin
      hund = 2'd1;
      hrem = 7'(hueh_q - 9'd100);
    end else begin
      hund = 2'd0;
      hrem = hueh_q[6:0];
    end
    tprod = {8'b0, hrem} * 15'd205;
    tens  = tprod[14:11];
    ones  = hrem - ({3'b0, tens} * 7'd10);
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (vh_q) begin
      pro_q  <= prh_q;
      pgo_q  <= pgh_q;
      pbo_q  <= pbh_q;
      hueo_q <= hueh_q;
      hbo_q  <= {hund, tens, ones[3:0]};
      bro_q  <= brh_q;
      bgo_q  <= bgh_q;
      bbo_q  <= bbh_q;
    end
  end

  assign done_o          = done_q;
  assign red_percent_o   = pro_q;
  assign green_percent_o = pgo_q;
  assign blue_percent_o  = pbo_q;
  assign hue_degrees_o   = hueo_q;
  assign hue_bcd_o       = hbo_q;
  assign red_bcd_o       = bro_q;
  assign green_bcd_o     = bgo_q;
  assign blue_bcd_o      = bbo_q;

endmodule

// ===== rtl/rhpb_chk.sv =====
// port-level checker for the colour sensor post-processing block, with its bind
`timescale 1ns / 1ps

module rhpb_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic [rhpb_pkg::PctW-1:0]    red_percent_o,
  input logic [rhpb_pkg::PctW-1:0]    green_percent_o,
  input logic [rhpb_pkg::PctW-1:0]    blue_percent_o,
  input logic [rhpb_pkg::HueW-1:0]    hue_degrees_o,
  input logic [rhpb_pkg::HueBcdW-1:0] hue_bcd_o
);

  // every request gives a result after the fixed latency
  a_req_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(rhpb_pkg::Latency) done_o)
    else $error("request without result");

  // no result without a request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, rhpb_pkg::Latency))
    else $error("result without request");

  // percentages in range
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (red_percent_o <= 7'd100) && (green_percent_o <= 7'd100)
               && (blue_percent_o <= 7'd100))
    else $error("percentage out of range");

  // hue in range and bcd digits valid
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hue_degrees_o < 9'd360) && (hue_bcd_o[3:0] <= 4'd9)
               && (hue_bcd_o[7:4] <= 4'd9))
    else $error("hue out of range");

endmodule

bind rgb_hue_percent_bcd rhpb_chk u_rhpb_chk (.*);

// ===== tb/sv/rgb_hue_percent_bcd_tb.sv =====
// testbench for the colour sensor post-processing block: predicted percentages, hue and bcd
`timescale 1ns / 1ps

module rgb_hue_percent_bcd_tb;
  import rhpb_pkg::*;

  typedef struct packed {
    logic [CountW-1:0] red;
    logic [CountW-1:0] green;
    logic [CountW-1:0] blue;
  } triple_t;

  typedef struct packed {
    logic [PctW-1:0]    red_pct;
    logic [PctW-1:0]    green_pct;
    logic [PctW-1:0]    blue_pct;
    logic [HueW-1:0]    hue;
    logic [HueBcdW-1:0] hue_bcd;
    logic [CntBcdW-1:0] red_bcd;
    logic [CntBcdW-1:0] green_bcd;
    logic [CntBcdW-1:0] blue_bcd;
  } colour_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CountW-1:0] red_count_i = '0, green_count_i = '0, blue_count_i = '0;
  logic done_o;
  logic [PctW-1:0] red_percent_o, green_percent_o, blue_percent_o;
  logic [HueW-1:0] hue_degrees_o;
  logic [HueBcdW-1:0] hue_bcd_o;
  logic [CntBcdW-1:0] red_bcd_o, green_bcd_o, blue_bcd_o;

  triple_t     pending_q[$];
  colour_res_t expected_q[$];
  int          n_errors = 0;
  bit          all_sent = 1'b0;
  int          gap_left = 0;

  rgb_hue_percent_bcd dut (.*);

  always #5 clk_i = ~clk_i;

  // packed decimal digits of a value
  function automatic logic [23:0] dec_digits(input int unsigned v, input int n);
    logic [23:0] r;
    r = '0;
    for (int i = 0; i < n; i++) begin
      r[4*i +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return r;
  endfunction

  function automatic logic [PctW-1:0] share_pct(input int unsigned c, input int unsigned tot);
    if (tot == 0) return '0;
    return PctW'((c * 100 + tot / 2) / tot);
  endfunction

  function automatic int unsigned hue_angle(input triple_t t);
    longint nr, ng, nb, lo, hi, spread, d, base, q, h;
    logic [1:0] top;
    nr = (longint'(t.red) * 4096) / 65535;
    ng = (longint'(t.green) * 4096) / 65535;
    nb = (longint'(t.blue) * 4096) / 65535;
    lo = nr; hi = nr; top = MaxRed;
    if (ng < lo) lo = ng;
    else if (ng > hi) begin hi = ng; top = MaxGreen; end
    if (nb < lo) lo = nb;
    else if (nb > hi) begin hi = nb; top = MaxBlue; end
    spread = hi - lo;
    if (spread == 0) return 0;
    case (top)
      MaxRed:   begin d = ng - nb; base = 0;    end
      MaxGreen: begin d = nb - nr; base = 512;  end
      default:  begin d = nr - ng; base = 1024; end
    endcase
    // systemverilog division truncates toward zero like the design's hue divider, which divides the magnitude
    q = (d * 256 + spread / 2) / spread;
    h = 60 * (base + q);
    if (h < 0) h += 360 * 256;
    return 32'(h / 256);
  endfunction

  function automatic colour_res_t predict_colour(input triple_t t);
    colour_res_t r;
    int unsigned tot, hue;
    tot = 32'(t.red) + 32'(t.green) + 32'(t.blue);
    hue = hue_angle(t);
    r.red_pct   = share_pct(32'(t.red), tot);
    r.green_pct = share_pct(32'(t.green), tot);
    r.blue_pct  = share_pct(32'(t.blue), tot);
    r.hue       = HueW'(hue);
    r.hue_bcd   = HueBcdW'(dec_digits(hue, 3));
    r.red_bcd   = CntBcdW'(dec_digits(32'(t.red), 5));
    r.green_bcd = CntBcdW'(dec_digits(32'(t.green), 5));
    r.blue_bcd  = CntBcdW'(dec_digits(32'(t.blue), 5));
    return r;
  endfunction

  function automatic logic [CountW-1:0] rand_count();
    case ($urandom_range(0, 5))
      0:       return CountW'($urandom_range(0, 20));
      1:       return CountW'(32'hFFFF - $urandom_range(0, 20));
      default: return CountW'($urandom);
    endcase
  endfunction

  // driver: one request per handshake with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_q.push_back(predict_colour({red_count_i, green_count_i, blue_count_i}));
      end
      if (start && busy) begin
        // hold request until taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        triple_t t;
        t = pending_q.pop_front();
        red_count_i <= t.red;
        green_count_i <= t.green;
        blue_count_i <= t.blue;
        start <= 1'b1;
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 5));
      end else begin
        start <= 1'b0;
        all_sent <= 1'b1;
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      colour_res_t got, exp_r;
      got = {red_percent_o, green_percent_o, blue_percent_o, hue_degrees_o, hue_bcd_o,
             red_bcd_o, green_bcd_o, blue_bcd_o};
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        n_errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.red_pct !== exp_r.red_pct)
          $display("%0t red_percent exp %0d got %0d", $time, exp_r.red_pct, got.red_pct);
        if (got.green_pct !== exp_r.green_pct)
          $display("%0t green_percent exp %0d got %0d", $time, exp_r.green_pct, got.green_pct);
        if (got.blue_pct !== exp_r.blue_pct)
          $display("%0t blue_percent exp %0d got %0d", $time, exp_r.blue_pct, got.blue_pct);
        if (got.hue !== exp_r.hue)
          $display("%0t hue_degrees exp %0d got %0d", $time, exp_r.hue, got.hue);
        if (got.hue_bcd !== exp_r.hue_bcd)
          $display("%0t hue_bcd exp %h got %h", $time, exp_r.hue_bcd, got.hue_bcd);
        if (got.red_bcd !== exp_r.red_bcd)
          $display("%0t red_bcd exp %h got %h", $time, exp_r.red_bcd, got.red_bcd);
        if (got.green_bcd !== exp_r.green_bcd)
          $display("%0t green_bcd exp %h got %h", $time, exp_r.green_bcd, got.green_bcd);
        if (got.blue_bcd !== exp_r.blue_bcd)
          $display("%0t blue_bcd exp %h got %h", $time, exp_r.blue_bcd, got.blue_bcd);
        if (got !== exp_r) n_errors++;
      end
    end
  end

  // stimulus and end of run
  initial begin
    // directed: extremes, zero total, flat, ties, each max channel, negative ratios
    pending_q.push_back('{16'h0000, 16'h0000, 16'h0000});
    pending_q.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF});
    pending_q.push_back('{16'hFFFF, 16'h0000, 16'h0000});
    pending_q.push_back('{16'h0000, 16'hFFFF, 16'h0000});
    pending_q.push_back('{16'h0000, 16'h0000, 16'hFFFF});
    pending_q.push_back('{16'hFFFF, 16'hFFFF, 16'h0000});
    pending_q.push_back('{16'hFFFF, 16'h0000, 16'hFFFF});
    pending_q.push_back('{16'h0000, 16'hFFFF, 16'hFFFF});
    pending_q.push_back('{16'd1000, 16'd100, 16'd500});
    pending_q.push_back('{16'd100, 16'd1000, 16'd500});
    pending_q.push_back('{16'd500, 16'd100, 16'd1000});
    pending_q.push_back('{16'd40000, 16'd10000, 16'd30000});
    pending_q.push_back('{16'd12345, 16'd54321, 16'd9999});
    pending_q.push_back('{16'd1, 16'd0, 16'd0});
    pending_q.push_back('{16'd5, 16'd3, 16'd7});
    pending_q.push_back('{16'd65534, 16'd1, 16'd32767});
    pending_q.push_back('{16'h5555, 16'hAAAA, 16'h5555});
    pending_q.push_back('{16'hAAAA, 16'h5555, 16'hAAAA});
    pending_q.push_back('{16'd34463, 16'd9, 16'd10});
    for (int i = 0; i < 1550; i++) begin
      triple_t t;
      t.red = rand_count();
      t.green = rand_count();
      t.blue = rand_count();
      if ($urandom_range(0, 9) == 0) t.green = t.red;
      pending_q.push_back(t);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (all_sent && expected_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (n_errors == 0 && expected_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== rgb_hue_percent_bcd.f =====
rtl/rhpb_pkg.sv
rtl/rgb_hue_percent_bcd.sv
rtl/rhpb_chk.sv
tb/sv/rgb_hue_percent_bcd_tb.sv
